@@ src/wav_pkg.sv @@
// Package for the WAV byte-stream parser: phase codes, status codes, tags.
// No dependencies.
package wav_pkg;
    localparam logic [2:0] PH_PREAMBLE = 3'd0;
    localparam logic [2:0] PH_HEADER   = 3'd1;
    localparam logic [2:0] PH_BODY     = 3'd2;
    localparam logic [2:0] PH_SAMPLES  = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_NO_RIFF  = 4'd2;
    localparam logic [3:0] ST_NO_WAVE  = 4'd3;
    localparam logic [3:0] ST_OVERRUN  = 4'd4;
    localparam logic [3:0] ST_NOT_PCM  = 4'd5;
    localparam logic [3:0] ST_NO_FMT   = 4'd6;
    localparam logic [3:0] ST_NO_DATA  = 4'd7;
    localparam logic [3:0] ST_LAYOUT   = 4'd8;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] LEN_RESET = 32'd44;
    localparam logic [31:0] LEN_MIN   = 32'd44;
    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] FMT_EXT   = 16'hFFFE;

    typedef struct packed {
        logic        kind;
        logic [3:0]  status;
        logic [7:0]  sample;
        logic        last_sample;
        logic [15:0] channels;
        logic [31:0] samp_rate;
        logic [15:0] samp_bits;
        logic [31:0] frame_count;
    } t_result;
endpackage

@@ src/wav_if.sv @@
// Valid/ready stream interfaces for file bytes and parser results.
// No dependencies.
interface wav_byte_if (input logic i_clk);
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    modport source (output valid, output file_byte, input ready);
    modport sink (input valid, input file_byte, output ready);
endinterface

interface wav_result_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  status;
    logic [7:0]  sample;
    logic        last_sample;
    logic [15:0] channels;
    logic [31:0] samp_rate;
    logic [15:0] samp_bits;
    logic [31:0] frame_count;
    modport source (output valid, output kind, output status, output sample,
                    output last_sample, output channels, output samp_rate,
                    output samp_bits, output frame_count, input ready);
    modport sink (input valid, input kind, input status, input sample,
                  input last_sample, input channels, input samp_rate,
                  input samp_bits, input frame_count, output ready);
endinterface

@@ src/wav_out_skid.sv @@
// Two-entry output buffer (result register plus skid) for parser results.
// Depends on wav_pkg.
module wav_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  wav_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output wav_pkg::t_result o_data,
    input  logic             i_ready
);
    logic             r_valid, r_skid_valid;
    wav_pkg::t_result r_data, r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || i_ready) begin
                if (r_skid_valid) begin
                    r_valid      <= 1'b1;
                    r_data       <= r_skid;
                    r_skid_valid <= i_valid;
                    r_skid       <= i_data;
                end else begin
                    r_valid <= i_valid;
                    r_data  <= i_data;
                end
            end else if (i_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_valid) else $error("skid full while output empty");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_data)))
        else $error("stalled result changed");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid) else $error("skid lost");
`endif
endmodule

@@ src/wav_stream_to_u8_mono.sv @@
// Top level of the RIFF/WAVE byte-stream parser with u8 mono conversion.
// Depends on wav_pkg, wav_if (wav_byte_if, wav_result_if) and wav_out_skid.
//
// Usage:
//  - Byte channel (wav_byte_if sink): one WAV file byte per transfer.
//  - Result channel (wav_result_if source): status (kind 0) at the data chunk
//    header or on error, then one unsigned 8-bit sample (kind 1) per frame.
//  - APB port: register 0 at address 0 is file_length (reset 44). Write only
//    while idle. The byte position wraps to zero after file_length bytes.
//  - Throughput: one byte per cycle while the result buffer has room. Each byte
//    is parsed by one pass of field-update logic into the parser registers; the
//    33-bit chunk-end compare is made on the last header byte.
//  - Result path: the result that a byte causes is registered in the result
//    buffer, in the result register or, when the receiver stalls, the skid.
//  - Receiver stall: a two-entry result buffer keeps bytes flowing; input
//    ready drops only once both entries are full.
//  - Reset: parse restarts at byte 0 expecting the RIFF tag, result buffer
//    empties, file_length returns to 44.
module wav_stream_to_u8_mono (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wav_byte_if.sink    s_in,
    wav_result_if.source m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] r_len;
    logic [31:0] r_pos, r_tag, r_size;
    logic [32:0] r_off;
    logic [2:0]  r_ph;
    logic [15:0] r_fmt, r_sub, r_chan, r_bits, r_first;
    logic [31:0] r_rate, r_left;
    logic        r_have;
    logic [1:0]  r_idx;
    logic [7:0]  r_low;

    logic [31:0] n_pos, n_tag, n_size;
    logic [32:0] n_off;
    logic [2:0]  n_ph;
    logic [15:0] n_fmt, n_sub, n_chan, n_bits, n_first;
    logic [31:0] n_rate, n_left;
    logic        n_have;
    logic [1:0]  n_idx;
    logic [7:0]  n_low;

    logic             res_v, buf_ready, acc;
    wav_pkg::t_result res, out_d;
    logic [7:0]  b;
    logic        last;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? r_len : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len <= wav_pkg::LEN_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) r_len <= pwdata;
    end

    assign s_in.ready = buf_ready;
    assign acc = s_in.valid && buf_ready;
    assign b = s_in.file_byte;
    assign last = r_pos >= (r_len - 32'd1);

    function automatic wav_pkg::t_result mk_status(input logic [3:0] code,
        input logic [15:0] ch, input logic [31:0] rt, input logic [15:0] bt,
        input logic [31:0] fr);
        wav_pkg::t_result t;
        logic show;
        show = (code == wav_pkg::ST_OK) || (code == wav_pkg::ST_LAYOUT);
        t = '0;
        t.status = code;
        t.channels = show ? ch : 16'd0;
        t.samp_rate = show ? rt : 32'd0;
        t.samp_bits = show ? bt : 16'd0;
        t.frame_count = (code == wav_pkg::ST_OK) ? fr : 32'd0;
        return t;
    endfunction

    always_comb begin
        logic [2:0]  k;
        logic [32:0] kb;
        logic        ext, stereo, wide, bodyok;
        logic [1:0]  lastidx;
        logic [1:0]  sh;
        logic [31:0] fr;
        logic [16:0] sum, sv;
        logic [7:0]  val;
        logic [31:0] tagw;
        n_pos = r_pos; n_tag = r_tag; n_size = r_size; n_off = r_off; n_ph = r_ph;
        n_fmt = r_fmt; n_sub = r_sub; n_chan = r_chan; n_bits = r_bits;
        n_first = r_first; n_rate = r_rate; n_left = r_left; n_have = r_have;
        n_idx = r_idx; n_low = r_low;
        res_v = 1'b0; res = '0;
        k = r_off[2:0]; kb = r_off;
        ext = r_size >= 32'd40;
        stereo = r_chan == 16'd2; wide = r_bits == 16'd16;
        lastidx = {stereo & wide, stereo | wide};
        sh = {1'b0, stereo} + {1'b0, wide};
        fr = r_size >> sh;
        sum = '0; sv = '0; val = '0; tagw = '0;
        bodyok = 1'b0;
        unique case (r_ph)
            wav_pkg::PH_PREAMBLE: begin
                if (r_pos == 32'd0 && r_len < wav_pkg::LEN_MIN) begin
                    n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
                    res = mk_status(wav_pkg::ST_SHORT, r_chan, r_rate, r_bits, 32'd0);
                end else if (r_pos < 32'd4) begin
                    tagw = wav_pkg::TAG_RIFF >> {r_pos[1:0], 3'b000};
                    if (b != tagw[7:0]) begin
                        n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
                        res = mk_status(wav_pkg::ST_NO_RIFF, r_chan, r_rate, r_bits, 32'd0);
                    end
                end else if (r_pos >= 32'd8 && r_pos < 32'd12) begin
                    tagw = wav_pkg::TAG_WAVE >> {r_pos[1:0], 3'b000};
                    if (b != tagw[7:0]) begin
                        n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
                        res = mk_status(wav_pkg::ST_NO_WAVE, r_chan, r_rate, r_bits, 32'd0);
                    end
                end
                if (!res_v && r_pos >= 32'd11) begin
                    n_ph = wav_pkg::PH_HEADER; n_off = '0;
                end
            end
            wav_pkg::PH_HEADER: begin
                unique case (k)
                    3'd0: n_tag = {24'd0, b};
                    3'd1: n_tag[15:8] = b;
                    3'd2: n_tag[23:16] = b;
                    3'd3: n_tag[31:24] = b;
                    3'd4: n_size = {24'd0, b};
                    3'd5: n_size[15:8] = b;
                    3'd6: n_size[23:16] = b;
                    default: n_size[31:24] = b;
                endcase
                n_off = {30'd0, k} + 33'd1;
                if (k == 3'd7) begin
                    n_off = '0;
                    if ({1'b0, r_pos} + 33'd1 + {1'b0, n_size} > {1'b0, r_len}) begin
                        n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
                        res = mk_status(wav_pkg::ST_OVERRUN, r_chan, r_rate, r_bits, 32'd0);
                    end else if (r_tag == wav_pkg::TAG_DATA) begin
                        n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
                        fr = n_size >> sh;
                        if (!r_have)
                            res = mk_status(wav_pkg::ST_NO_FMT, r_chan, r_rate, r_bits, 32'd0);
                        else if ((r_chan != 16'd1 && r_chan != 16'd2) ||
                                 (r_bits != 16'd8 && r_bits != 16'd16))
                            res = mk_status(wav_pkg::ST_LAYOUT, r_chan, r_rate, r_bits, 32'd0);
                        else begin
                            n_left = fr; n_idx = 2'd0;
                            if (fr != 32'd0) n_ph = wav_pkg::PH_SAMPLES;
                            res = mk_status(wav_pkg::ST_OK, r_chan, r_rate, r_bits, fr);
                        end
                    end else if (n_size != 32'd0) begin
                        n_ph = wav_pkg::PH_BODY;
                    end
                end
            end
            wav_pkg::PH_BODY: begin
                bodyok = r_tag == wav_pkg::TAG_FMT && r_size >= 32'd16 &&
                         kb < {1'b0, r_size};
                if (bodyok) begin
                    if (kb == 33'd0) n_fmt = {8'd0, b};
                    if (kb == 33'd1) n_fmt[15:8] = b;
                    if (kb == 33'd2) n_chan = {8'd0, b};
                    if (kb == 33'd3) n_chan[15:8] = b;
                    if (kb == 33'd4) n_rate = {24'd0, b};
                    if (kb == 33'd5) n_rate[15:8] = b;
                    if (kb == 33'd6) n_rate[23:16] = b;
                    if (kb == 33'd7) n_rate[31:24] = b;
                    if (kb == 33'd14) n_bits = {8'd0, b};
                    if (kb == 33'd15) n_bits[15:8] = b;
                    if (kb == 33'd24) n_sub = {8'd0, b};
                    if (kb == 33'd25) n_sub[15:8] = b;
                    if (kb == 33'd1 && n_fmt != wav_pkg::FMT_PCM &&
                        !(n_fmt == wav_pkg::FMT_EXT && ext)) begin
                        n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
                        res = mk_status(wav_pkg::ST_NOT_PCM, r_chan, r_rate, r_bits, 32'd0);
                    end
                    if (kb == 33'd15 && r_fmt == wav_pkg::FMT_PCM) n_have = 1'b1;
                    if (kb == 33'd25 && r_fmt == wav_pkg::FMT_EXT && ext) begin
                        if (n_sub != 16'd1) begin
                            n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
                            res = mk_status(wav_pkg::ST_NOT_PCM, r_chan, r_rate, r_bits,
                                            32'd0);
                        end else n_have = 1'b1;
                    end
                end
                if (!res_v) begin
                    n_off = r_off + 33'd1;
                    if (n_off >= {1'b0, r_size} + {32'd0, r_size[0]}) begin
                        n_off = '0; n_ph = wav_pkg::PH_HEADER;
                    end
                end
            end
            wav_pkg::PH_SAMPLES: begin
                if (wide) begin
                    if (!r_idx[0]) n_low = b;
                    else if (r_idx == 2'd1 && stereo) n_first = {b, r_low};
                end else if (r_idx == 2'd0) n_first = {8'd0, b};
                if (r_idx < lastidx) n_idx = r_idx + 2'd1;
                else begin
                    n_idx = 2'd0;
                    if (!wide) begin
                        sum = {9'd0, r_first[7:0]} + {9'd0, b};
                        val = stereo ? sum[8:1] : b;
                    end else begin
                        // signed average truncated toward zero, then offset binary
                        sum = {r_first[15], r_first} + {b[7], b, r_low};
                        sv = (sum[16] && sum[0]) ? sum + 17'd1 : sum;
                        val = stereo ? (sv[16:9] ^ 8'h80) : (b ^ 8'h80);
                    end
                    n_left = r_left - 32'd1;
                    if (n_left == 32'd0) n_ph = wav_pkg::PH_DONE;
                    res_v = 1'b1; res = '0; res.kind = 1'b1; res.sample = val;
                    res.last_sample = r_left == 32'd1;
                end
            end
            default: n_ph = wav_pkg::PH_DONE;
        endcase
        if (!res_v && last && (n_ph == wav_pkg::PH_PREAMBLE ||
            n_ph == wav_pkg::PH_HEADER || n_ph == wav_pkg::PH_BODY)) begin
            n_ph = wav_pkg::PH_DONE; res_v = 1'b1;
            res = mk_status(wav_pkg::ST_NO_DATA, r_chan, r_rate, r_bits, 32'd0);
        end
        if (last) begin
            n_pos = '0; n_ph = wav_pkg::PH_PREAMBLE; n_tag = '0; n_size = '0;
            n_off = '0; n_fmt = '0; n_sub = '0; n_chan = '0; n_rate = '0;
            n_bits = '0; n_have = 1'b0; n_left = '0; n_idx = '0; n_first = '0;
            n_low = '0;
        end else n_pos = r_pos + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_ph <= wav_pkg::PH_PREAMBLE; r_tag <= '0; r_size <= '0;
            r_off <= '0; r_fmt <= '0; r_sub <= '0; r_chan <= '0; r_rate <= '0;
            r_bits <= '0; r_have <= 1'b0; r_left <= '0; r_idx <= '0;
            r_first <= '0; r_low <= '0;
        end else if (acc) begin
            r_pos <= n_pos; r_ph <= n_ph; r_tag <= n_tag; r_size <= n_size;
            r_off <= n_off; r_fmt <= n_fmt; r_sub <= n_sub; r_chan <= n_chan;
            r_rate <= n_rate; r_bits <= n_bits; r_have <= n_have; r_left <= n_left;
            r_idx <= n_idx; r_first <= n_first; r_low <= n_low;
        end
    end

    wav_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc && res_v),
        .i_data  (res),
        .o_ready (buf_ready),
        .o_valid (m_out.valid),
        .o_data  (out_d),
        .i_ready (m_out.ready)
    );

    assign m_out.kind        = out_d.kind;
    assign m_out.status      = out_d.status;
    assign m_out.sample      = out_d.sample;
    assign m_out.last_sample = out_d.last_sample;
    assign m_out.channels    = out_d.channels;
    assign m_out.samp_rate   = out_d.samp_rate;
    assign m_out.samp_bits   = out_d.samp_bits;
    assign m_out.frame_count = out_d.frame_count;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == wav_pkg::PH_SAMPLES) |-> (r_idx <= {r_chan == 16'd2 && r_bits == 16'd16,
        (r_chan == 16'd2) || (r_bits == 16'd16)})) else $error("frame index overflow");
    a_samples_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == wav_pkg::PH_SAMPLES) |-> (r_left != 32'd0)) else $error("no frames left");
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last) |=> (r_pos == 32'd0 && r_ph == wav_pkg::PH_PREAMBLE))
        else $error("position did not wrap");
`endif
endmodule
